// ===== hw/rtl/vdmlc_pkg.sv =====
// Package for the versioned direct-mapped lookup cache.
// Holds the slot count, the payload and slot types, the opcodes and the hash function.
// No dependencies.
`timescale 1ns / 1ps

package vdmlc_pkg;

  // The slot count must be a power of two between 2 and 256.
  localparam int unsigned SLOT_COUNT = 16;
  localparam int unsigned IDX_W = $clog2(SLOT_COUNT);

  localparam logic [31:0] HASH_MULT = 32'd2654435761;
  localparam logic [IDX_W-1:0] HASH_MULT_LO = HASH_MULT[IDX_W-1:0];

  typedef logic [IDX_W-1:0] idx_t;

  typedef enum logic [1:0] {
    OP_LOOKUP     = 2'd0,
    OP_FILL       = 2'd1,
    OP_INVALIDATE = 2'd2,
    OP_CLEAR_ALL  = 2'd3
  } opcode_t;

  typedef struct packed {
    opcode_t     opcode;
    logic [31:0] type_number;
    logic [31:0] object_number;
    logic [23:0] object_version;
    logic [47:0] fill_reference;
  } in_t;

  typedef struct packed {
    logic        hit;
    logic [47:0] hit_reference;
    logic [3:0]  slot_index;
  } out_t;

  typedef struct packed {
    logic [63:0] key;
    logic [23:0] version;
    logic [47:0] reference;
  } slot_t;

  typedef struct packed {
    logic        en;
    opcode_t     opcode;
    idx_t        index;
    logic [31:0] object_number;
    slot_t       entry;
  } slot_cmd_t;

  // Only the low index bits of the 64-bit hash matter for a power-of-two slot count.
  function automatic idx_t hash_index(logic [31:0] type_number, logic [31:0] object_number);
    logic [2*IDX_W-1:0] prod;
    logic [IDX_W-1:0]   sum;
    prod = type_number[IDX_W-1:0] * HASH_MULT_LO;
    sum  = prod[IDX_W-1:0] + object_number[IDX_W-1:0];
    return sum;
  endfunction

  function automatic logic [3:0] index_field(idx_t index);
    logic [IDX_W+3:0] wide;
    wide = {4'b0000, index};
    return wide[3:0];
  endfunction

endpackage

// ===== hw/rtl/versioned_direct_mapped_lookup_cache.sv =====
// Top level of the versioned direct-mapped lookup cache.
// Uses vdmlc_pkg, vdmlc_in_stage and vdmlc_slot_file.
//
//   Channel  Signals                        Payload
//   input    in_valid / in_ready / in_data  vdmlc_pkg::in_t
//   output   out_valid / out_ready / out_data  vdmlc_pkg::out_t
//
// Each transaction passes an input register and then a result register.
// One transaction is accepted per cycle while the result channel is not stalled.
// The slot file is read and updated in the same cycle.
// Reset clears every slot at once; the block accepts input in the cycle after reset.
// A stalled result holds the input register, which then stalls the input channel.
`timescale 1ns / 1ps

module versioned_direct_mapped_lookup_cache (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  vdmlc_pkg::in_t  in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output vdmlc_pkg::out_t out_data
);
  import vdmlc_pkg::*;

  logic      advance;
  logic      s1_valid;
  in_t       s1_data;
  slot_cmd_t cmd;
  slot_t     rd_slot;
  idx_t      index;
  out_t      result;

  assign advance = !out_valid || out_ready;

  vdmlc_in_stage u_in_stage (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .advance  (advance),
    .s1_valid (s1_valid),
    .s1_data  (s1_data)
  );

  assign index = hash_index(s1_data.type_number, s1_data.object_number);

  always_comb begin
    cmd.en               = s1_valid && advance;
    cmd.opcode           = s1_data.opcode;
    cmd.index            = index;
    cmd.object_number    = s1_data.object_number;
    cmd.entry.key        = {s1_data.type_number, s1_data.object_number};
    cmd.entry.version    = s1_data.object_version;
    cmd.entry.reference  = s1_data.fill_reference;
  end

  vdmlc_slot_file u_slot_file (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .rd_slot (rd_slot)
  );

  always_comb begin
    result = '0;
    case (s1_data.opcode)
      OP_LOOKUP: begin
        result.hit           = (rd_slot.key == cmd.entry.key)
                               && (rd_slot.version == s1_data.object_version);
        result.hit_reference = rd_slot.reference;
        result.slot_index    = index_field(index);
      end
      OP_FILL: begin
        result.hit_reference = s1_data.fill_reference;
        result.slot_index    = index_field(index);
      end
      default: begin
        result = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      out_data <= result;
    end
  end

endmodule

// ===== hw/rtl/vdmlc_in_stage.sv =====
// Input register stage of the versioned direct-mapped lookup cache.
// Depends on vdmlc_pkg for the input payload type.
`timescale 1ns / 1ps

module vdmlc_in_stage (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  vdmlc_pkg::in_t in_data,
  input  logic          advance,
  output logic          s1_valid,
  output vdmlc_pkg::in_t s1_data
);
  import vdmlc_pkg::*;

  assign in_ready = !rst && (!s1_valid || advance);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_data <= in_data;
    end
  end

endmodule

// ===== hw/rtl/vdmlc_slot_file.sv =====
// Slot register file of the versioned direct-mapped lookup cache.
// Applies fill, invalidate and clear commands and reads one slot. Depends on vdmlc_pkg.
`timescale 1ns / 1ps

module vdmlc_slot_file (
  input  logic                 clk,
  input  logic                 rst,
  input  vdmlc_pkg::slot_cmd_t cmd,
  output vdmlc_pkg::slot_t     rd_slot
);
  import vdmlc_pkg::*;

  slot_t slots [SLOT_COUNT];

  assign rd_slot = slots[cmd.index];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
        slots[i] <= '0;
      end
    end else if (cmd.en) begin
      case (cmd.opcode)
        OP_FILL: begin
          slots[cmd.index] <= cmd.entry;
        end
        OP_INVALIDATE: begin
          for (int i = 0; i < SLOT_COUNT; i++) begin
            if (slots[i].key[31:0] == cmd.object_number) begin
              slots[i].key       <= '0;
              slots[i].reference <= '0;
            end
          end
        end
        OP_CLEAR_ALL: begin
          for (int i = 0; i < SLOT_COUNT; i++) begin
            slots[i] <= '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== hw/rtl/vdmlc_checker.sv =====
// Port-level checker for the versioned direct-mapped lookup cache, with its bind.
// Depends on vdmlc_pkg and on the top level's port list.
`timescale 1ns / 1ps

module vdmlc_checker (
  input logic            clk,
  input logic            rst,
  input logic            in_valid,
  input logic            in_ready,
  input vdmlc_pkg::in_t  in_data,
  input logic            out_valid,
  input logic            out_ready,
  input vdmlc_pkg::out_t out_data
);
  import vdmlc_pkg::*;

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("Result valid in the cycle after reset.");

  a_ready_follows: assert property (@(posedge clk) disable iff (rst)
    (out_ready || !out_valid) |-> in_ready)
    else $error("Input stalled although the result side can move.");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("Stalled result changed or was dropped.");

  a_in_busy: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("Input stalled without a stalled result.");

endmodule

bind versioned_direct_mapped_lookup_cache vdmlc_checker u_vdmlc_checker (.*);
